@@ rtl/button_press_event_queue_unit_defines.svh @@
// Assertion macros shared by the button press queue checker.
`ifndef BUTTON_PRESS_EVENT_QUEUE_UNIT_DEFINES_SVH
`define BUTTON_PRESS_EVENT_QUEUE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPEQ_ASSERT_SAME(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("button press queue check failed");

// The consequent must hold in the cycle after the antecedent.
`define BPEQ_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("button press queue check failed");

`endif

@@ rtl/bpeq_pkg.sv @@
// Shared constants and operation codes of the button press queue.
package bpeq_pkg;

  localparam int QueueDepth  = 8;
  localparam int ButtonCount = 4;

  localparam int LevelW  = 4;
  localparam int OpW     = 2;
  localparam int NumberW = 2;
  localparam int ShownW  = 4;

  localparam int CountW   = $clog2(QueueDepth + 1);
  localparam int IdxW     = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int ScanPins = (ButtonCount < LevelW) ? ButtonCount : LevelW;

  typedef enum logic [OpW-1:0] {
    OpSample = 2'd0,
    OpPop    = 2'd1,
    OpFlush  = 2'd2,
    OpUnused = 2'd3
  } op_e;

endpackage

@@ rtl/button_press_event_queue_unit.sv @@
// Button press queue: edge detection on the button levels and a press FIFO.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------------------
//   in      | input     | in_valid_i, in_stall_o | operation_i, pin_levels_i
//   out     | output    | out_valid_o, out_stall_i | press_valid_o, button_number_o,
//           |           |                        | queue_count_o
//
// The scan, the pop shift and the count update sit between the state registers and
// the result register, so one beat a cycle while the output side does not stall.
// A result appears in the cycle after its input beat is accepted.
// Reset clears the entry count, the last levels and the result valid flag.
// The input stalls only while a result is held and the output side stalls.
module button_press_event_queue_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [bpeq_pkg::OpW-1:0]    operation_i,
  input  logic [bpeq_pkg::LevelW-1:0] pin_levels_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        press_valid_o,
  output logic [bpeq_pkg::NumberW-1:0] button_number_o,
  output logic [bpeq_pkg::ShownW-1:0] queue_count_o
);
  import bpeq_pkg::*;

  logic [NumberW-1:0] store_q [QueueDepth];
  logic [NumberW-1:0] store_d [QueueDepth];
  logic [CountW-1:0]  count_q, count_d;
  logic [LevelW-1:0]  prev_q, prev_d;
  logic               out_valid_q;
  logic               press_q, press_d;
  logic [NumberW-1:0] number_q, number_d;
  logic [ShownW-1:0]  shown_q, shown_d;
  logic               in_accept;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  always_comb begin : next_state
    logic done;
    store_d  = store_q;
    count_d  = count_q;
    prev_d   = prev_q;
    press_d  = 1'b0;
    number_d = '0;
    done     = 1'b0;
    unique case (operation_i)
      OpSample: begin
        if (count_q < CountW'(QueueDepth)) begin
          for (int pin = 0; pin < ScanPins; pin++) begin
            if (!done) begin
              if (pin_levels_i[pin] && !prev_q[pin]) begin
                store_d[count_d[IdxW-1:0]] = NumberW'(pin);
                count_d = count_d + CountW'(1);
                if (count_d == CountW'(QueueDepth)) begin
                  done = 1'b1;
                end
              end else if (!pin_levels_i[pin] && prev_q[pin]) begin
                count_d = '0;
              end
            end
          end
        end
        prev_d = pin_levels_i;
      end
      OpPop: begin
        if (count_q != '0) begin
          press_d  = 1'b1;
          number_d = store_q[0];
          for (int i = 1; i < QueueDepth; i++) begin
            store_d[i-1] = store_q[i];
          end
          count_d = count_q - CountW'(1);
        end
      end
      OpFlush: begin
        count_d = '0;
        prev_d  = '0;
      end
      default: begin
      end
    endcase
    if (32'(count_d) > 32'd15) begin
      shown_d = ShownW'(15);
    end else begin
      shown_d = ShownW'(count_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      store_q  <= store_d;
      press_q  <= press_d;
      number_q <= number_d;
      shown_q  <= shown_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        count_q     <= count_d;
        prev_q      <= prev_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign press_valid_o   = press_q;
  assign button_number_o = number_q;
  assign queue_count_o   = shown_q;

endmodule

@@ rtl/bpeq_checker.sv @@
// Port-level checker for the button press queue, bound to the top level.
`include "button_press_event_queue_unit_defines.svh"

module bpeq_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic [bpeq_pkg::OpW-1:0]     operation_i,
  input logic [bpeq_pkg::LevelW-1:0]  pin_levels_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         press_valid_o,
  input logic [bpeq_pkg::NumberW-1:0] button_number_o,
  input logic [bpeq_pkg::ShownW-1:0]  queue_count_o
);
  import bpeq_pkg::*;

  localparam int MaxShown = (QueueDepth > 15) ? 15 : QueueDepth;

  // An input beat may only be held back while a result is waiting.
  `BPEQ_ASSERT_SAME(a_stall_needs_result, clk_i, rst_ni, in_stall_o, out_valid_o)

  // A result without a press always reports button number zero.
  `BPEQ_ASSERT_SAME(a_no_press_zero, clk_i, rst_ni, out_valid_o && !press_valid_o, button_number_o == '0)

  // The reported count never exceeds the queue depth.
  `BPEQ_ASSERT_SAME(a_count_bound, clk_i, rst_ni, out_valid_o, 32'(queue_count_o) <= MaxShown)

  // A stalled result beat holds its payload.
  `BPEQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(press_valid_o) && $stable(button_number_o) && $stable(queue_count_o))

endmodule

bind button_press_event_queue_unit bpeq_checker u_bpeq_checker (.*);
